// ===== src/allfl_pkg.sv =====
// ----------------------------------------------------------------------------
// allfl_pkg
// Shared types and constants for the array-based linked list with free list.
// ----------------------------------------------------------------------------
package allfl_pkg;

  // Store geometry
  localparam int unsigned DEPTH  = 64;
  localparam int unsigned IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned LINK_W = 7;
  localparam logic [LINK_W-1:0] NIL = 7'd127;
  localparam logic [LINK_W-1:0] DEPTH_LINK = LINK_W'(DEPTH);
  localparam logic [IDX_W:0]    DEPTH_CNT  = (IDX_W+1)'(DEPTH);

  // Input mode codes
  localparam logic [2:0] MODE_INS  = 3'd0;
  localparam logic [2:0] MODE_APP  = 3'd1;
  localparam logic [2:0] MODE_DEL  = 3'd2;
  localparam logic [2:0] MODE_LIST = 3'd3;
  localparam logic [2:0] MODE_CLR  = 3'd4;

  // Result status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_NODE  = 2'd3;

  // Decoded operation
  typedef enum logic [2:0] {
    OP_INS,
    OP_APP,
    OP_DEL,
    OP_LIST,
    OP_CLR,
    OP_NOP
  } op_e;

  // One queued command
  typedef struct packed {
    op_e         op;
    logic [31:0] number;
    logic [63:0] name_low;
    logic [7:0]  name_high;
  } cmd_t;

endpackage

// ===== src/allfl_front.sv =====
// ----------------------------------------------------------------------------
// allfl_front
// Accepts input items, decodes the mode and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module allfl_front import allfl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  mode_i,
  input  logic [31:0] number_i,
  input  logic [63:0] name_low_i,
  input  logic [7:0]  name_high_i,
  output logic        q_valid_o,
  output cmd_t        q_cmd_o,
  input  logic        q_pop_i
);

  cmd_t       fifo_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;
  cmd_t       cmd_in;

  // Mode decode
  always_comb begin
    cmd_in.number    = number_i;
    cmd_in.name_low  = name_low_i;
    cmd_in.name_high = name_high_i;
    case (mode_i)
      MODE_INS:  cmd_in.op = OP_INS;
      MODE_APP:  cmd_in.op = OP_APP;
      MODE_DEL:  cmd_in.op = OP_DEL;
      MODE_LIST: cmd_in.op = OP_LIST;
      MODE_CLR:  cmd_in.op = OP_CLR;
      default:   cmd_in.op = OP_NOP;
    endcase
  end

  assign in_ready_o = (cnt_q != 2'd2);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_cmd_o    = fifo_q[rd_ptr_q];
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_pop_i && q_valid_o;

  // Pointer and count update
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

// ===== src/allfl_back.sv =====
// ----------------------------------------------------------------------------
// allfl_back
// Executes queued commands on the node store and drives the result register.
// ----------------------------------------------------------------------------
module allfl_back import allfl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  input  cmd_t        q_cmd_i,
  output logic        q_pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [31:0] number_res_o,
  output logic [63:0] name_low_res_o,
  output logic [7:0]  name_high_res_o,
  output logic        last_o
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_WALK  = 9'b000000010,
    S_ALLOC = 9'b000000100,
    S_FREE  = 9'b000001000,
    S_WRITE = 9'b000010000,
    S_LINK  = 9'b000100000,
    S_DROP  = 9'b001000000,
    S_LIST  = 9'b010000000,
    S_RESP  = 9'b100000000
  } state_e;

  // Node store
  logic [31:0]       num_mem  [DEPTH];
  logic [71:0]       name_mem [DEPTH];
  logic [LINK_W-1:0] link_mem [DEPTH];
  logic [LINK_W-1:0] free_mem [DEPTH];

  state_e            state_q, state_d;
  cmd_t              cmd_q, cmd_d;
  logic              clr_q, clr_d;
  logic [LINK_W-1:0] head_q, head_d;
  logic [LINK_W-1:0] fhead_q, fhead_d;
  logic [IDX_W:0]    used_q, used_d;
  logic [LINK_W-1:0] p_q, p_d;
  logic [IDX_W-1:0]  s_q, s_d;
  logic [1:0]        resp_q, resp_d;

  logic              link_re, link_we, data_re, data_we, free_re, free_we;
  logic [IDX_W-1:0]  link_ra, link_wa, data_ra, free_ra, free_wa;
  logic [LINK_W-1:0] link_wd, free_wd;
  logic [LINK_W-1:0] link_rd, free_rd;
  logic [31:0]       num_rd;
  logic [71:0]       name_rd;

  logic              out_valid_q;
  logic [1:0]        status_q;
  logic [31:0]       number_q;
  logic [71:0]       name_q;
  logic              last_q;
  logic              emit, emit_node, emit_last;
  logic [1:0]        emit_status;
  logic              out_free, head_ok, link_ok, fhead_ok, full;

  assign out_free = !out_valid_q || out_ready_i;
  assign head_ok  = head_q < DEPTH_LINK;
  assign link_ok  = link_rd < DEPTH_LINK;
  assign fhead_ok = fhead_q < DEPTH_LINK;
  assign full     = !fhead_ok && (used_q == DEPTH_CNT);

  // Command sequencer
  always_comb begin
    state_d = state_q;
    cmd_d   = cmd_q;
    clr_d   = clr_q;
    head_d  = head_q;
    fhead_d = fhead_q;
    used_d  = used_q;
    p_d     = p_q;
    s_d     = s_q;
    resp_d  = resp_q;
    q_pop_o = 1'b0;
    link_re = 1'b0; link_ra = head_q[IDX_W-1:0];
    link_we = 1'b0; link_wa = s_q; link_wd = NIL;
    data_re = 1'b0; data_ra = head_q[IDX_W-1:0];
    data_we = 1'b0;
    free_re = 1'b0; free_ra = fhead_q[IDX_W-1:0];
    free_we = 1'b0; free_wa = head_q[IDX_W-1:0]; free_wd = fhead_q;
    emit        = 1'b0;
    emit_node   = 1'b0;
    emit_last   = 1'b1;
    emit_status = resp_q;
    case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          cmd_d   = q_cmd_i;
          clr_d   = (q_cmd_i.op == OP_CLR);
          p_d     = head_q;
          case (q_cmd_i.op)
            OP_INS, OP_APP: begin
              if (full) begin
                resp_d  = ST_FULL;
                state_d = S_RESP;
              end else if (q_cmd_i.op == OP_APP && head_ok) begin
                link_re = 1'b1;
                state_d = S_WALK;
              end else begin
                state_d = S_ALLOC;
              end
            end
            OP_DEL, OP_CLR: begin
              if (!head_ok) begin
                resp_d  = (q_cmd_i.op == OP_DEL) ? ST_EMPTY : ST_DONE;
                state_d = S_RESP;
              end else begin
                link_re = 1'b1;
                state_d = S_DROP;
              end
            end
            OP_LIST: begin
              if (!head_ok) begin
                resp_d  = ST_EMPTY;
                state_d = S_RESP;
              end else begin
                link_re = 1'b1;
                data_re = 1'b1;
                state_d = S_LIST;
              end
            end
            default: begin
              resp_d  = ST_DONE;
              state_d = S_RESP;
            end
          endcase
        end
      end
      // follow links to the tail
      S_WALK: begin
        if (link_ok) begin
          p_d     = link_rd;
          link_re = 1'b1;
          link_ra = link_rd[IDX_W-1:0];
        end else begin
          state_d = S_ALLOC;
        end
      end
      // take a released slot first, else a fresh one
      S_ALLOC: begin
        if (fhead_ok) begin
          free_re = 1'b1;
          s_d     = fhead_q[IDX_W-1:0];
          state_d = S_FREE;
        end else begin
          s_d     = used_q[IDX_W-1:0];
          used_d  = used_q + 1'b1;
          state_d = S_WRITE;
        end
      end
      S_FREE: begin
        fhead_d = free_rd;
        state_d = S_WRITE;
      end
      S_WRITE: begin
        data_we = 1'b1;
        link_we = 1'b1;
        link_wd = (cmd_q.op == OP_INS) ? head_q : NIL;
        if (cmd_q.op == OP_INS || !head_ok) begin
          head_d  = LINK_W'(s_q);
          resp_d  = ST_DONE;
          state_d = S_RESP;
        end else begin
          state_d = S_LINK;
        end
      end
      // hook the new node behind the tail
      S_LINK: begin
        link_we = 1'b1;
        link_wa = p_q[IDX_W-1:0];
        link_wd = LINK_W'(s_q);
        resp_d  = ST_DONE;
        state_d = S_RESP;
      end
      // unlink head, push its slot onto the free list
      S_DROP: begin
        head_d  = link_rd;
        free_we = 1'b1;
        fhead_d = head_q;
        if (clr_q && link_ok) begin
          link_re = 1'b1;
          link_ra = link_rd[IDX_W-1:0];
        end else begin
          resp_d  = ST_DONE;
          state_d = S_RESP;
        end
      end
      // one node per result
      S_LIST: begin
        if (out_free) begin
          emit        = 1'b1;
          emit_node   = 1'b1;
          emit_status = ST_NODE;
          emit_last   = !link_ok;
          if (link_ok) begin
            link_re = 1'b1;
            data_re = 1'b1;
            link_ra = link_rd[IDX_W-1:0];
            data_ra = link_rd[IDX_W-1:0];
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_RESP: begin
        if (out_free) begin
          emit    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= NIL;
      fhead_q <= NIL;
      used_q  <= '0;
      clr_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      fhead_q <= fhead_d;
      used_q  <= used_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    p_q    <= p_d;
    s_q    <= s_d;
    resp_q <= resp_d;
  end

  // Link store
  always_ff @(posedge clk_i) begin
    if (link_we) link_mem[link_wa] <= link_wd;
    if (link_re) link_rd <= link_mem[link_ra];
  end

  // Free-list store
  always_ff @(posedge clk_i) begin
    if (free_we) free_mem[free_wa] <= free_wd;
    if (free_re) free_rd <= free_mem[free_ra];
  end

  // Record store
  always_ff @(posedge clk_i) begin
    if (data_we) begin
      num_mem[s_q]  <= cmd_q.number;
      name_mem[s_q] <= {cmd_q.name_high, cmd_q.name_low};
    end
    if (data_re) begin
      num_rd  <= num_mem[data_ra];
      name_rd <= name_mem[data_ra];
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      status_q <= emit_status;
      number_q <= emit_node ? num_rd : '0;
      name_q   <= emit_node ? name_rd : '0;
      last_q   <= emit_last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign number_res_o    = number_q;
  assign name_low_res_o  = name_q[63:0];
  assign name_high_res_o = name_q[71:64];
  assign last_o          = last_q;

endmodule

// ===== src/array_linked_list_free_list.sv =====
// Linked list in a 64-slot node store with a free list of released slots.
// Append walks the list one node per cycle to the tail; list and clear take
// one node per cycle (list only while the result register is free), each step
// bound by one read of the single link store port.
// A two-entry input queue takes items while the back end works.
// Reset: list and free list empty, no slot used; node store is not cleared.
module array_linked_list_free_list import allfl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  mode_i,
  input  logic [31:0] number_i,
  input  logic [63:0] name_low_i,
  input  logic [7:0]  name_high_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [31:0] number_res_o,
  output logic [63:0] name_low_res_o,
  output logic [7:0]  name_high_res_o,
  output logic        last_o
);

  logic q_valid, q_pop;
  cmd_t q_cmd;

  allfl_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .mode_i, .number_i, .name_low_i, .name_high_i,
    .q_valid_o (q_valid),
    .q_cmd_o   (q_cmd),
    .q_pop_i   (q_pop)
  );

  allfl_back u_back (
    .clk_i, .rst_ni,
    .q_valid_i (q_valid),
    .q_cmd_i   (q_cmd),
    .q_pop_o   (q_pop),
    .out_valid_o, .out_ready_i,
    .status_o, .number_res_o, .name_low_res_o, .name_high_res_o, .last_o
  );

  // Status-only results carry a zero payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_NODE |->
      number_res_o == '0 && name_low_res_o == '0 && name_high_res_o == '0)
    else $error("nonzero payload on status result");

  // Only listed nodes may leave last low
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> status_o == ST_NODE)
    else $error("non-node result without last");

  // A result that is not the last of a listing is followed by a node
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_o ##1 out_valid_o |-> status_o == ST_NODE)
    else $error("listing broken by a status result");

endmodule
